>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the design files; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/cgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_pkg
// Types and constants of the calibrated gain/phase point pipeline.
// ----------------------------------------------------------------------------
package cgp_pkg;

  // field widths
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 24;
  localparam int AMP_W   = 16;
  localparam int FREQ_W  = 27;
  localparam int STAT_W  = 8;
  localparam int SCALE_W = 40;   // samples times amplitude
  localparam int SQ_W    = 80;   // scale squared
  localparam int GAIN_W  = 24;
  localparam int PHASE_W = 16;

  // wide multiplier
  localparam int MUL_W   = 96;
  localparam int PROD_W  = 192;
  localparam int CHUNK_W = 24;
  localparam int CHUNKS  = 4;
  localparam int ROW_W   = MUL_W + CHUNK_W;
  localparam int MUL1_N  = 10;

  // powers, phasor terms, root
  localparam int MAG_W    = 96;
  localparam int SGN_W    = 97;
  localparam int LHS_W    = 176;
  localparam int RHS_W    = 208;
  localparam int GL_W     = 200;
  localparam int X_W      = 226;

  // ratio divider and arctangent
  localparam int QUO_W     = 17;
  localparam int QUO_STEPS = 17;
  localparam int DSM_W     = 97;
  localparam int TERM_W    = 38;
  localparam int KQ_W      = 37;
  localparam int ATP_W     = 55;
  localparam int ANG_W     = 14;
  localparam logic [19:0]        ATAN_K     = 20'd1025134;
  localparam logic [QUO_W-1:0]   ATAN_ONE   = 17'h10000;
  localparam logic [TERM_W-1:0]  DEG45_Q32  = 38'd193273528320;
  localparam logic [ATP_W-1:0]   ATAN_ROUND = 55'd1099511627776;
  localparam logic [ANG_W-1:0]   DEG90_Q7   = 14'd11520;
  localparam logic signed [PHASE_W-1:0] DEG180_Q7 = 16'sd23040;

  // pipeline depth up to the output register
  localparam int STAGES = 32;

  // configuration
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_MASK = 1'b1;

  typedef struct packed {
    logic signed [ACC_W-1:0] cal_in_phase;
    logic signed [ACC_W-1:0] cal_quadrature;
    logic [CNT_W-1:0]        cal_samples;
    logic [AMP_W-1:0]        cal_amplitude;
    logic [FREQ_W-1:0]       cal_frequency;
    logic signed [ACC_W-1:0] meas_in_phase;
    logic signed [ACC_W-1:0] meas_quadrature;
    logic [CNT_W-1:0]        meas_samples;
    logic [STAT_W-1:0]       meas_status;
    logic [AMP_W-1:0]        adc_peak;
    logic [AMP_W-1:0]        adc_floor;
    logic [AMP_W-1:0]        drive_amplitude;
  } in_word_t;

  typedef struct packed {
    logic                      point_ok;
    logic [FREQ_W-1:0]         point_frequency;
    logic [GAIN_W-1:0]         gain;
    logic signed [PHASE_W-1:0] phase;
  } out_word_t;

endpackage

>>> design/cgp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_ifs
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface cgp_in_if;
  logic               valid;
  logic               ready;
  cgp_pkg::in_word_t  word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface cgp_out_if;
  logic               valid;
  logic               ready;
  cgp_pkg::out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

>>> design/cgp_mul96.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_mul96
// 96x96 unsigned multiplier in three stages: 24-bit partial products,
// row sums, final sum.
// ----------------------------------------------------------------------------
module cgp_mul96 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [cgp_pkg::MUL_W-1:0]   a,
  input  logic [cgp_pkg::MUL_W-1:0]   b,
  output logic [cgp_pkg::PROD_W-1:0]  p
);

  logic [2*cgp_pkg::CHUNK_W-1:0] pp_r [cgp_pkg::CHUNKS][cgp_pkg::CHUNKS];
  logic [cgp_pkg::ROW_W-1:0]     row_r [cgp_pkg::CHUNKS];
  logic [cgp_pkg::ROW_W-1:0]     row_nxt [cgp_pkg::CHUNKS];
  logic [cgp_pkg::PROD_W-1:0]    p_r;
  logic [cgp_pkg::PROD_W-1:0]    p_nxt;

  always_comb begin
    for (int i = 0; i < cgp_pkg::CHUNKS; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < cgp_pkg::CHUNKS; j++) begin
        row_nxt[i] = row_nxt[i] +
                     (cgp_pkg::ROW_W'(pp_r[i][j]) << (cgp_pkg::CHUNK_W * j));
      end
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < cgp_pkg::CHUNKS; i++) begin
      p_nxt = p_nxt + (cgp_pkg::PROD_W'(row_r[i]) << (cgp_pkg::CHUNK_W * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < cgp_pkg::CHUNKS; i++) begin
        for (int j = 0; j < cgp_pkg::CHUNKS; j++) begin
          pp_r[i][j] <= a[i*cgp_pkg::CHUNK_W +: cgp_pkg::CHUNK_W] *
                        b[j*cgp_pkg::CHUNK_W +: cgp_pkg::CHUNK_W];
        end
        row_r[i] <= row_nxt[i];
      end
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

>>> design/cgp_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgp_root
// Pipelined bit-serial root: largest g with g*g*lhs <= rhs, one bit of g
// per stage, most significant first.
// ----------------------------------------------------------------------------
module cgp_root (
  input  logic                         clk,
  input  logic                         en,
  input  logic [cgp_pkg::RHS_W-1:0]    rhs,
  input  logic [cgp_pkg::LHS_W-1:0]    lhs,
  output logic [cgp_pkg::GAIN_W-1:0]   root
);

  // e: rhs - g*g*lhs, gl: g*lhs
  logic [cgp_pkg::RHS_W-1:0]  e_r  [cgp_pkg::GAIN_W];
  logic [cgp_pkg::GL_W-1:0]   gl_r [cgp_pkg::GAIN_W];
  logic [cgp_pkg::LHS_W-1:0]  l_r  [cgp_pkg::GAIN_W];
  logic [cgp_pkg::GAIN_W-1:0] g_r  [cgp_pkg::GAIN_W];

  for (genvar k = 0; k < cgp_pkg::GAIN_W; k++) begin : g_step
    localparam int B = cgp_pkg::GAIN_W - 1 - k;
    logic [cgp_pkg::RHS_W-1:0]  e_in;
    logic [cgp_pkg::GL_W-1:0]   gl_in;
    logic [cgp_pkg::LHS_W-1:0]  l_in;
    logic [cgp_pkg::GAIN_W-1:0] g_in;
    logic [cgp_pkg::X_W-1:0]    x;
    logic [cgp_pkg::X_W:0]      diff;
    logic                       take;

    if (k == 0) begin : g_first
      assign e_in  = rhs;
      assign gl_in = '0;
      assign l_in  = lhs;
      assign g_in  = '0;
    end else begin : g_next
      assign e_in  = e_r[k-1];
      assign gl_in = gl_r[k-1];
      assign l_in  = l_r[k-1];
      assign g_in  = g_r[k-1];
    end

    // (g + 2^B)^2 * L - g^2 * L
    assign x = (cgp_pkg::X_W'(gl_in) << (B + 1)) + (cgp_pkg::X_W'(l_in) << (2 * B));
    assign diff = {1'b0, cgp_pkg::X_W'(e_in)} - {1'b0, x};
    assign take = !diff[cgp_pkg::X_W];

    always_ff @(posedge clk) begin
      if (en) begin
        l_r[k] <= l_in;
        if (take) begin
          e_r[k]  <= diff[cgp_pkg::RHS_W-1:0];
          gl_r[k] <= gl_in + (cgp_pkg::GL_W'(l_in) << B);
          g_r[k]  <= g_in | (cgp_pkg::GAIN_W'(1) << B);
        end else begin
          e_r[k]  <= e_in;
          gl_r[k] <= gl_in;
          g_r[k]  <= g_in;
        end
      end
    end
  end

  assign root = g_r[cgp_pkg::GAIN_W-1];

endmodule

>>> design/calibrated_gain_phase_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_gain_phase_point
// Through-calibrated gain and phase of one sweep point.
// ----------------------------------------------------------------------------
// Input words arrive on in_ch (valid/ready), each holding a bypass
// calibration phasor and a device measurement. Every accepted word gives
// exactly one result word on out_ch: point_ok, frequency, gain (Q8.16,
// saturating) and phase (degrees, Q9.7). Rejected points come out with
// point_ok low and all other fields zero.
// Throughput is one word per cycle while the output is not held. The
// 24-stage gain root sets the pipeline depth, with the 17-stage ratio
// divider and arctangent in parallel.
// The two status masks are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty.
// Reset (rst_n low, synchronous) clears both masks and all valid bits.
// When out_ch.ready is low the result holds in the output register; the
// pipeline keeps accepting words until its last stage is full, then
// stalls as a whole, empty stages included.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calibrated_gain_phase_point (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cgp_pkg::CFG_DATA_W-1:0]    cfg_data,
  cgp_in_if.sink                            in_ch,
  cgp_out_if.source                         out_ch
);

  typedef struct packed {
    logic                       rej;
    logic [cgp_pkg::FREQ_W-1:0] freq;
  } side_t;

  typedef struct packed {
    logic ci;
    logic cq;
    logic mi;
    logic mq;
  } sign_t;

  typedef struct packed {
    logic zero;
    logic re_neg;
    logic im_neg;
    logic swap;
  } pflag_t;

  function automatic logic [cgp_pkg::ACC_W-1:0] mag48(input logic [cgp_pkg::ACC_W-1:0] x);
    return x[cgp_pkg::ACC_W-1] ? (cgp_pkg::ACC_W'(0) - x) : x;
  endfunction

  function automatic logic signed [cgp_pkg::SGN_W-1:0] apply_sign(
    input logic neg, input logic [cgp_pkg::MAG_W-1:0] m);
    return neg ? (cgp_pkg::SGN_W'(0) - {1'b0, m}) : {1'b0, m};
  endfunction

  logic [cgp_pkg::STAT_W-1:0] bad_mask_r;
  logic [cgp_pkg::STAT_W-1:0] req_mask_r;

  logic                       en;
  logic [cgp_pkg::STAGES:1]   v_r;
  side_t                      side_r [1:cgp_pkg::STAGES];
  logic                       rej_nxt;

  // stage 1
  logic [cgp_pkg::ACC_W-1:0]   ci_abs_r, cq_abs_r, mi_abs_r, mq_abs_r;
  logic [cgp_pkg::SCALE_W-1:0] nn_r, dd_r;
  sign_t                       sgn_r [1:4];

  // stages 2..4
  logic [cgp_pkg::MUL_W-1:0]  mul1_a [cgp_pkg::MUL1_N];
  logic [cgp_pkg::MUL_W-1:0]  mul1_b [cgp_pkg::MUL1_N];
  logic [cgp_pkg::PROD_W-1:0] mul1_p [cgp_pkg::MUL1_N];

  // stage 5
  logic [cgp_pkg::MAG_W-1:0]        pc_r, pm_r;
  logic signed [cgp_pkg::SGN_W-1:0] t_re1_r, t_re2_r, t_im1_r, t_im2_r;
  logic [cgp_pkg::SQ_W-1:0]         nn2_r, dd2_r;

  // stages 6..8
  logic signed [cgp_pkg::SGN_W-1:0] re_r, im_r;
  logic [cgp_pkg::MAG_W-1:0]        are_r, aim_r;
  logic [cgp_pkg::MAG_W-1:0]        small_r, large_r;
  pflag_t                           pf_r [7:28];
  logic [cgp_pkg::PROD_W-1:0]       rhs_p, lhs_p;

  // divider, stages 9..25
  logic [cgp_pkg::DSM_W-1:0] dsm_r [cgp_pkg::QUO_STEPS];
  logic [cgp_pkg::MAG_W-1:0] dlg_r [cgp_pkg::QUO_STEPS];
  logic [cgp_pkg::QUO_W-1:0] dq_r  [cgp_pkg::QUO_STEPS];

  // arctangent, stages 26..29, then phase delay to the last stage
  logic [cgp_pkg::QUO_W-1:0]  r_r;
  logic [cgp_pkg::KQ_W-1:0]   kq;
  logic [cgp_pkg::TERM_W-1:0] term_r;
  logic [cgp_pkg::ATP_W-1:0]  prod_r;
  logic [cgp_pkg::ATP_W-1:0]  rounded;
  logic [cgp_pkg::ANG_W-1:0]  f_ang;
  logic [cgp_pkg::ANG_W-1:0]  ang_r;
  logic signed [cgp_pkg::PHASE_W-1:0] sa;
  logic signed [cgp_pkg::PHASE_W-1:0] ph_nxt;
  logic signed [cgp_pkg::PHASE_W-1:0] ph_r [4];

  logic [cgp_pkg::GAIN_W-1:0] gain_root;

  logic               out_valid_r;
  cgp_pkg::out_word_t out_word_r;
  cgp_pkg::out_word_t out_word_nxt;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_mask_r <= '0;
      req_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cgp_pkg::REG_BAD_MASK: bad_mask_r <= cfg_data;
        cgp_pkg::REG_REQ_MASK: req_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance unless the last stage is full and the output register is held
  assign en = !v_r[cgp_pkg::STAGES] || !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign rej_nxt = ((in_ch.word.meas_status & bad_mask_r) != '0) ||
                   ((in_ch.word.meas_status & req_mask_r) != req_mask_r) ||
                   (in_ch.word.meas_samples == '0) ||
                   (in_ch.word.adc_peak <= in_ch.word.adc_floor) ||
                   (in_ch.word.cal_samples == '0) ||
                   (in_ch.word.cal_amplitude == '0) ||
                   (in_ch.word.drive_amplitude == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[cgp_pkg::STAGES-1:1], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= '{rej: rej_nxt, freq: in_ch.word.cal_frequency};
      for (int k = 2; k <= cgp_pkg::STAGES; k++) begin
        if (k != 6) begin
          side_r[k] <= side_r[k-1];
        end
      end
      // calibration power of one or less rejects
      side_r[6] <= '{rej: side_r[5].rej || (pc_r <= cgp_pkg::MAG_W'(1)),
                     freq: side_r[5].freq};
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      ci_abs_r <= mag48(in_ch.word.cal_in_phase);
      cq_abs_r <= mag48(in_ch.word.cal_quadrature);
      mi_abs_r <= mag48(in_ch.word.meas_in_phase);
      mq_abs_r <= mag48(in_ch.word.meas_quadrature);
      nn_r     <= in_ch.word.cal_samples * in_ch.word.cal_amplitude;
      dd_r     <= in_ch.word.meas_samples * in_ch.word.drive_amplitude;
      sgn_r[1] <= '{ci: in_ch.word.cal_in_phase[cgp_pkg::ACC_W-1],
                    cq: in_ch.word.cal_quadrature[cgp_pkg::ACC_W-1],
                    mi: in_ch.word.meas_in_phase[cgp_pkg::ACC_W-1],
                    mq: in_ch.word.meas_quadrature[cgp_pkg::ACC_W-1]};
      for (int k = 2; k <= 4; k++) begin
        sgn_r[k] <= sgn_r[k-1];
      end
    end
  end

  // ------------------------------------------------------- stages 2..4
  // squares, cross products and scale squares on magnitudes
  always_comb begin
    mul1_a[0] = cgp_pkg::MUL_W'(ci_abs_r);  mul1_b[0] = cgp_pkg::MUL_W'(ci_abs_r);
    mul1_a[1] = cgp_pkg::MUL_W'(cq_abs_r);  mul1_b[1] = cgp_pkg::MUL_W'(cq_abs_r);
    mul1_a[2] = cgp_pkg::MUL_W'(mi_abs_r);  mul1_b[2] = cgp_pkg::MUL_W'(mi_abs_r);
    mul1_a[3] = cgp_pkg::MUL_W'(mq_abs_r);  mul1_b[3] = cgp_pkg::MUL_W'(mq_abs_r);
    mul1_a[4] = cgp_pkg::MUL_W'(mi_abs_r);  mul1_b[4] = cgp_pkg::MUL_W'(ci_abs_r);
    mul1_a[5] = cgp_pkg::MUL_W'(mq_abs_r);  mul1_b[5] = cgp_pkg::MUL_W'(cq_abs_r);
    mul1_a[6] = cgp_pkg::MUL_W'(mq_abs_r);  mul1_b[6] = cgp_pkg::MUL_W'(ci_abs_r);
    mul1_a[7] = cgp_pkg::MUL_W'(mi_abs_r);  mul1_b[7] = cgp_pkg::MUL_W'(cq_abs_r);
    mul1_a[8] = cgp_pkg::MUL_W'(nn_r);      mul1_b[8] = cgp_pkg::MUL_W'(nn_r);
    mul1_a[9] = cgp_pkg::MUL_W'(dd_r);      mul1_b[9] = cgp_pkg::MUL_W'(dd_r);
  end

  for (genvar m = 0; m < cgp_pkg::MUL1_N; m++) begin : g_mul1
    cgp_mul96 u_mul (
      .clk (clk),
      .en  (en),
      .a   (mul1_a[m]),
      .b   (mul1_b[m]),
      .p   (mul1_p[m])
    );
  end

  // ---------------------------------------------------------------- stage 5
  always_ff @(posedge clk) begin
    if (en) begin
      pc_r    <= mul1_p[0][cgp_pkg::MAG_W-1:0] + mul1_p[1][cgp_pkg::MAG_W-1:0];
      pm_r    <= mul1_p[2][cgp_pkg::MAG_W-1:0] + mul1_p[3][cgp_pkg::MAG_W-1:0];
      t_re1_r <= apply_sign(sgn_r[4].mi ^ sgn_r[4].ci, mul1_p[4][cgp_pkg::MAG_W-1:0]);
      t_re2_r <= apply_sign(sgn_r[4].mq ^ sgn_r[4].cq, mul1_p[5][cgp_pkg::MAG_W-1:0]);
      t_im1_r <= apply_sign(sgn_r[4].mq ^ sgn_r[4].ci, mul1_p[6][cgp_pkg::MAG_W-1:0]);
      t_im2_r <= apply_sign(sgn_r[4].mi ^ sgn_r[4].cq, mul1_p[7][cgp_pkg::MAG_W-1:0]);
      nn2_r   <= mul1_p[8][cgp_pkg::SQ_W-1:0];
      dd2_r   <= mul1_p[9][cgp_pkg::SQ_W-1:0];
    end
  end

  // ---------------------------------------------------- stages 6..8, gain
  cgp_mul96 u_mul_rhs (
    .clk (clk),
    .en  (en),
    .a   (pm_r),
    .b   (cgp_pkg::MUL_W'(nn2_r)),
    .p   (rhs_p)
  );

  cgp_mul96 u_mul_lhs (
    .clk (clk),
    .en  (en),
    .a   (pc_r),
    .b   (cgp_pkg::MUL_W'(dd2_r)),
    .p   (lhs_p)
  );

  cgp_root u_root (
    .clk  (clk),
    .en   (en),
    .rhs  ({rhs_p[cgp_pkg::LHS_W-1:0], 32'd0}),
    .lhs  (lhs_p[cgp_pkg::LHS_W-1:0]),
    .root (gain_root)
  );

  // ------------------------------------------------- stages 6..8, phasor
  always_ff @(posedge clk) begin
    if (en) begin
      re_r  <= t_re1_r + t_re2_r;
      im_r  <= t_im1_r - t_im2_r;
      are_r <= re_r[cgp_pkg::SGN_W-1] ? cgp_pkg::MAG_W'(-re_r) : cgp_pkg::MAG_W'(re_r);
      aim_r <= im_r[cgp_pkg::SGN_W-1] ? cgp_pkg::MAG_W'(-im_r) : cgp_pkg::MAG_W'(im_r);
      pf_r[7] <= '{zero: (re_r == '0) && (im_r == '0),
                   re_neg: re_r[cgp_pkg::SGN_W-1],
                   im_neg: im_r[cgp_pkg::SGN_W-1],
                   swap: 1'b0};
      // take the smaller magnitude over the larger
      pf_r[8] <= '{zero: pf_r[7].zero,
                   re_neg: pf_r[7].re_neg,
                   im_neg: pf_r[7].im_neg,
                   swap: aim_r > are_r};
      for (int k = 9; k <= 28; k++) begin
        pf_r[k] <= pf_r[k-1];
      end
      small_r <= (aim_r > are_r) ? are_r : aim_r;
      large_r <= (aim_r > are_r) ? aim_r : are_r;
    end
  end

  // ------------------------------------------------ stages 9..25, divide
  for (genvar k = 0; k < cgp_pkg::QUO_STEPS; k++) begin : g_div
    logic [cgp_pkg::DSM_W-1:0] s_in;
    logic [cgp_pkg::MAG_W-1:0] l_in;
    logic [cgp_pkg::QUO_W-1:0] q_in;
    logic                      ge;
    logic [cgp_pkg::DSM_W-1:0] s_rem;

    if (k == 0) begin : g_first
      assign s_in = cgp_pkg::DSM_W'(small_r);
      assign l_in = large_r;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = dsm_r[k-1];
      assign l_in = dlg_r[k-1];
      assign q_in = dq_r[k-1];
    end

    assign ge    = s_in >= cgp_pkg::DSM_W'(l_in);
    assign s_rem = ge ? (s_in - cgp_pkg::DSM_W'(l_in)) : s_in;

    always_ff @(posedge clk) begin
      if (en) begin
        dsm_r[k] <= {s_rem[cgp_pkg::DSM_W-2:0], 1'b0};
        dlg_r[k] <= l_in;
        dq_r[k]  <= {q_in[cgp_pkg::QUO_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------- stages 26..29, arctangent
  assign kq      = cgp_pkg::ATAN_K * (cgp_pkg::ATAN_ONE - dq_r[cgp_pkg::QUO_STEPS-1]);
  assign rounded = prod_r + cgp_pkg::ATAN_ROUND;
  assign f_ang   = rounded[cgp_pkg::ATP_W-1 -: cgp_pkg::ANG_W];
  assign sa      = cgp_pkg::PHASE_W'(ang_r);

  always_comb begin
    if (pf_r[28].zero) begin
      ph_nxt = '0;
    end else if (pf_r[28].re_neg) begin
      ph_nxt = pf_r[28].im_neg ? (sa - cgp_pkg::DEG180_Q7) : (cgp_pkg::DEG180_Q7 - sa);
    end else begin
      ph_nxt = pf_r[28].im_neg ? -sa : sa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= dq_r[cgp_pkg::QUO_STEPS-1];
      term_r <= cgp_pkg::DEG45_Q32 + cgp_pkg::TERM_W'(kq);
      prod_r <= r_r * term_r;
      ang_r  <= pf_r[27].swap ? (cgp_pkg::DEG90_Q7 - f_ang) : f_ang;
      ph_r[0] <= ph_nxt;
      for (int k = 1; k < 4; k++) begin
        ph_r[k] <= ph_r[k-1];
      end
    end
  end

  // --------------------------------------------------------- output word
  always_comb begin
    out_word_nxt = '0;
    if (!side_r[cgp_pkg::STAGES].rej) begin
      out_word_nxt.point_ok        = 1'b1;
      out_word_nxt.point_frequency = side_r[cgp_pkg::STAGES].freq;
      out_word_nxt.gain            = gain_root;
      out_word_nxt.phase           = ph_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= v_r[cgp_pkg::STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.word  = out_word_r;

  // ------------------------------------------------------------ checks
  `ASSERT_IMPLIES(a_reject_clears, clk, rst_n, out_ch.valid && !out_ch.word.point_ok, (out_ch.word.gain == '0) && (out_ch.word.phase == '0) && (out_ch.word.point_frequency == '0))
  `ASSERT_IMPLIES(a_phase_range, clk, rst_n, out_ch.valid, (out_ch.word.phase >= -16'sd23040) && (out_ch.word.phase <= 16'sd23040))
  `ASSERT_IMPLIES(a_stall_only_full, clk, rst_n, !in_ch.ready, out_ch.valid && !out_ch.ready && v_r[cgp_pkg::STAGES])
  `ASSERT_NEXT(a_tail_moves_out, clk, rst_n, v_r[cgp_pkg::STAGES] && (!out_ch.valid || out_ch.ready), out_ch.valid)

endmodule
